// ===== src/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg: shared types and codes for the submatrix multiply core
// Field widths, operation, status and register codes, and the cell token.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int ELEM_W      = 16;
  localparam int RES_W       = 40;
  localparam int PROD_W      = 32;
  localparam int REG_W       = 5;
  localparam int EXT_W       = 7;   // holds any sum of two registers or MAX_DIM
  localparam int K_W         = 6;   // index width at the largest MAX_DIM
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] OP_WR_LEFT  = 2'd0;
  localparam logic [1:0] OP_WR_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHAPE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_START   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL_START   = 3'd6;

  // one left element travelling down the cell chain
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic              nul;
    logic [K_W-1:0]    k;
    logic [K_W-1:0]    r;
    logic [ELEM_W-1:0] a;
  } tok_t;

endpackage

// ===== src/smm_if.sv =====
// ----------------------------------------------------------------------------
// smm_if: channel interfaces of the submatrix multiply core
// Command input, result output and register write channels.
// ----------------------------------------------------------------------------
interface smm_in_if;
  import smm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [3:0]               row;
  logic [3:0]               col;
  logic signed [ELEM_W-1:0] value;
  modport source(output valid, operation, row, col, value, input ready);
  modport sink(input valid, operation, row, col, value, output ready);
endinterface

interface smm_out_if;
  import smm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [RES_W-1:0] result_value;
  modport source(output valid, status, result_value, input ready);
  modport sink(input valid, status, result_value, output ready);
endinterface

interface smm_cfg_if;
  import smm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/smm_ram.sv =====
// ----------------------------------------------------------------------------
// smm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/smm_cell.sv =====
// ----------------------------------------------------------------------------
// smm_cell: one result column of the multiply chain
// Holds its right-matrix column and result column, multiplies the passing
// left element by its right entry and accumulates; forwards the token.
// ----------------------------------------------------------------------------
module smm_cell #(
  parameter int MAX_DIM = 16,
  parameter int IDX = 0,
  localparam int IW = $clog2(MAX_DIM)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  smm_pkg::tok_t             tok_in,
  output smm_pkg::tok_t             tok_out,
  input  logic                      rwe,
  input  logic [IW-1:0]             rwaddr,
  input  logic [smm_pkg::ELEM_W-1:0] rwdata,
  input  logic                      clr_en,
  input  logic [IW-1:0]             clr_addr,
  input  logic [smm_pkg::REG_W-1:0] right_cols,
  input  logic [IW-1:0]             rd_addr,
  output logic [smm_pkg::RES_W-1:0] rd_data
);
  import smm_pkg::*;

  tok_t              tok_r;
  tok_t              ptok_r;
  logic [ELEM_W-1:0] b_rdata;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [RES_W-1:0]  acc_r;
  logic [RES_W-1:0]  acc_nxt;
  logic              cell_on;
  logic              res_we;
  logic [IW-1:0]     res_waddr;
  logic [RES_W-1:0]  res_wdata;

  smm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_right (
    .clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwdata),
    .raddr(tok_in.k[IW-1:0]), .rdata(b_rdata)
  );

  assign prod_nxt = tok_r.nul ? '0 :
                    PROD_W'($signed(tok_r.a) * $signed(b_rdata));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld  <= 1'b0;
      ptok_r.vld <= 1'b0;
    end else begin
      tok_r.vld  <= tok_in.vld;
      ptok_r.vld <= tok_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r.first  <= tok_in.first;
    tok_r.last   <= tok_in.last;
    tok_r.nul    <= tok_in.nul;
    tok_r.k      <= tok_in.k;
    tok_r.r      <= tok_in.r;
    tok_r.a      <= tok_in.a;
    ptok_r.first <= tok_r.first;
    ptok_r.last  <= tok_r.last;
    ptok_r.nul   <= tok_r.nul;
    ptok_r.k     <= tok_r.k;
    ptok_r.r     <= tok_r.r;
    ptok_r.a     <= tok_r.a;
    prod_r       <= prod_nxt;
    if (ptok_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign tok_out = tok_r;
  assign acc_nxt = (ptok_r.first ? '0 : acc_r) +
                   {{(RES_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign cell_on = EXT_W'(IDX) < {{(EXT_W-REG_W){1'b0}}, right_cols};

  assign res_we    = clr_en | (ptok_r.vld & ptok_r.last & cell_on);
  assign res_waddr = clr_en ? clr_addr : ptok_r.r[IW-1:0];
  assign res_wdata = clr_en ? '0 : acc_nxt;

  smm_ram #(.WIDTH(RES_W), .DEPTH(MAX_DIM)) u_result (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(rd_addr), .rdata(rd_data)
  );
endmodule

// ===== src/submatrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// submatrix_multiply_core: windowed dense matrix multiply, Q8.8 in, Q24.16 out
// Sequencer, left store and a chain of MAX_DIM column cells.
// ----------------------------------------------------------------------------
// Element writes return nothing; a result read passes through the registered
// RAM read and then the registered column select, and the next item is taken
// once the read is out. After reset the result columns are cleared before the
// first item is taken. A compute streams one left element per cycle down the
// chain of MAX_DIM column cells, window_rows * max(window_cols, 1) elements in
// all, then drains the chain and reports its status; a compute with a shape
// error answers in the cycle after it is accepted.
module submatrix_multiply_core #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input logic clk,
  input logic rst_n,
  smm_in_if.sink    in_chan,
  smm_out_if.source out_chan,
  smm_cfg_if.sink   cfg_chan
);
  import smm_pkg::*;

  localparam int IW       = $clog2(MAX_DIM);
  localparam int LAW      = $clog2(MAX_DIM * MAX_DIM);
  localparam int DRAIN    = MAX_DIM + 4;
  localparam int DW       = $clog2(DRAIN);
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [REG_W-1:0] lr_r, lc_r, rc_r, wr_r, wc_r, rs_r, cs_r;
  logic [1:0]       state_r, state_nxt;
  logic [IW-1:0]    clr_cnt_r;
  logic [EXT_W-1:0] r_cnt_r, k_cnt_r, r_cnt_nxt, k_cnt_nxt;
  logic [DW-1:0]    drn_cnt_r, drn_cnt_nxt;
  logic             s1_vld_r, s1_bad_r;
  logic [IW-1:0]    s1_col_r;
  logic             out_vld_r, out_vld_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [RES_W-1:0] out_val_r, out_val_nxt;
  tok_t             lt_r, lt_nxt;
  tok_t             chain [MAX_DIM+1];
  logic [RES_W-1:0] col_data [MAX_DIM];

  logic [EXT_W-1:0] lr7, lc7, rc7, wr7, wc7, rs7, cs7, row7, col7, md7, kmax7;
  logic             in_acc, in_store, shape_bad, last_k, rd_bad;
  logic [IW-1:0]    row_i, col_i;
  logic [LAW-1:0]   l_waddr, l_raddr;
  logic [ELEM_W-1:0] l_rdata;

  assign lr7  = EXT_W'(lr_r);
  assign lc7  = EXT_W'(lc_r);
  assign rc7  = EXT_W'(rc_r);
  assign wr7  = EXT_W'(wr_r);
  assign wc7  = EXT_W'(wc_r);
  assign rs7  = EXT_W'(rs_r);
  assign cs7  = EXT_W'(cs_r);
  assign row7 = EXT_W'(in_chan.row);
  assign col7 = EXT_W'(in_chan.col);
  assign md7  = EXT_W'(MAX_DIM);
  assign row_i = row7[IW-1:0];
  assign col_i = col7[IW-1:0];

  assign in_store  = (row7 < md7) && (col7 < md7);
  assign shape_bad = (lr7 == '0) || (lr7 > md7) || (lc7 == '0) || (lc7 > md7) ||
                     (rc7 == '0) || (rc7 > md7) || (wr7 > md7) || (wc7 > md7) ||
                     (rs7 + wr7 > lr7) || (cs7 + wc7 > lc7);
  assign rd_bad    = !in_store || (row7 >= wr7) || (col7 >= rc7);

  // configuration registers
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= REG_W'(16);
      lc_r <= REG_W'(16);
      rc_r <= REG_W'(16);
      wr_r <= REG_W'(16);
      wc_r <= REG_W'(16);
      rs_r <= '0;
      cs_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_LEFT_ROWS:   lr_r <= cfg_chan.data;
        REG_LEFT_COLS:   lc_r <= cfg_chan.data;
        REG_RIGHT_COLS:  rc_r <= cfg_chan.data;
        REG_WINDOW_ROWS: wr_r <= cfg_chan.data;
        REG_WINDOW_COLS: wc_r <= cfg_chan.data;
        REG_ROW_START:   rs_r <= cfg_chan.data;
        REG_COL_START:   cs_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == S_IDLE) && !s1_vld_r &&
                         (!out_vld_r || out_chan.ready);
  assign in_acc = in_chan.valid && in_chan.ready;

  // left store
  assign l_waddr = LAW'(row_i) * LAW'(MAX_DIM) + LAW'(col_i);
  assign l_raddr = LAW'(rs7 + r_cnt_r) * LAW'(MAX_DIM) + LAW'(cs7 + k_cnt_r);

  smm_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM * MAX_DIM)) u_left (
    .clk(clk),
    .we(in_acc && (in_chan.operation == OP_WR_LEFT) && in_store),
    .waddr(l_waddr), .wdata(in_chan.value),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // sequencer
  assign kmax7  = (wc7 == '0) ? EXT_W'(1) : wc7;
  assign last_k = (k_cnt_r + EXT_W'(1)) == kmax7;

  always_comb begin
    state_nxt   = state_r;
    r_cnt_nxt   = r_cnt_r;
    k_cnt_nxt   = k_cnt_r;
    drn_cnt_nxt = drn_cnt_r;
    lt_nxt       = '0;
    lt_nxt.vld   = (state_r == S_RUN);
    lt_nxt.first = (k_cnt_r == '0);
    lt_nxt.last  = last_k;
    lt_nxt.nul   = (wc7 == '0);
    lt_nxt.k     = K_W'(k_cnt_r);
    lt_nxt.r     = K_W'(r_cnt_r);
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == IW'(MAX_DIM - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && (in_chan.operation == OP_COMPUTE) && !shape_bad) begin
          r_cnt_nxt   = '0;
          k_cnt_nxt   = '0;
          drn_cnt_nxt = '0;
          state_nxt   = (wr7 == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if (last_k) begin
          k_cnt_nxt = '0;
          r_cnt_nxt = r_cnt_r + EXT_W'(1);
          if (r_cnt_r + EXT_W'(1) == wr7) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          k_cnt_nxt = k_cnt_r + EXT_W'(1);
        end
      end
      S_DRAIN: begin
        drn_cnt_nxt = drn_cnt_r + DW'(1);
        if (drn_cnt_r == DW'(DRAIN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      lt_r.vld  <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_r + IW'(1);
      lt_r.vld  <= lt_nxt.vld;
      s1_vld_r  <= in_acc && (in_chan.operation == OP_READ);
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_cnt_r    <= r_cnt_nxt;
    k_cnt_r    <= k_cnt_nxt;
    drn_cnt_r  <= drn_cnt_nxt;
    lt_r.first <= lt_nxt.first;
    lt_r.last  <= lt_nxt.last;
    lt_r.nul   <= lt_nxt.nul;
    lt_r.k     <= lt_nxt.k;
    lt_r.r     <= lt_nxt.r;
    lt_r.a     <= lt_nxt.a;
    s1_bad_r   <= rd_bad;
    s1_col_r   <= col_i;
    out_st_r   <= out_st_nxt;
    out_val_r  <= out_val_nxt;
  end

  // head of the chain: token metadata lines up with the registered left read
  always_comb begin
    chain[0]   = lt_r;
    chain[0].a = l_rdata;
  end

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    smm_cell #(.MAX_DIM(MAX_DIM), .IDX(c)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .tok_in(chain[c]), .tok_out(chain[c+1]),
      .rwe(in_acc && (in_chan.operation == OP_WR_RIGHT) && in_store &&
           (col_i == IW'(c))),
      .rwaddr(row_i), .rwdata(in_chan.value),
      .clr_en(state_r == S_CLEAR), .clr_addr(clr_cnt_r),
      .right_cols(rc_r), .rd_addr(row_i), .rd_data(col_data[c])
    );
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r && !out_chan.ready;
    out_st_nxt  = out_st_r;
    out_val_nxt = out_val_r;
    if (s1_vld_r) begin
      out_vld_nxt = 1'b1;
      out_st_nxt  = s1_bad_r ? ST_RANGE : ST_OK;
      out_val_nxt = s1_bad_r ? '0 : col_data[s1_col_r];
    end else if (in_acc && (in_chan.operation == OP_COMPUTE) && shape_bad) begin
      out_vld_nxt = 1'b1;
      out_st_nxt  = ST_SHAPE;
      out_val_nxt = '0;
    end else if ((state_r == S_DRAIN) && (drn_cnt_r == DW'(DRAIN - 1))) begin
      out_vld_nxt = 1'b1;
      out_st_nxt  = ST_OK;
      out_val_nxt = '0;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.status       = out_st_r;
  assign out_chan.result_value = out_val_r;
endmodule
